>>> rtl/grid_maze_dfs_solver_unit_macros.svh
// ----------------------------------------------------------------------------
// Grid maze solver assertion macros
// Shorthand for clocked properties with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef GRID_MAZE_DFS_SOLVER_UNIT_MACROS_SVH
`define GRID_MAZE_DFS_SOLVER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMDS_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMDS_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/gmds_pkg.sv
// ----------------------------------------------------------------------------
// Grid maze solver package
// Field widths, operation codes, cell marks and the stack control type.
// ----------------------------------------------------------------------------
package gmds_pkg;

    localparam int OP_W      = 2;
    localparam int COORD_W   = 6;
    localparam int DIM_W     = 7;
    localparam int MARK_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int DIR_W     = 3;

    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_SOLVE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [MARK_W-1:0] MARK_WALL = 2'd0;
    localparam logic [MARK_W-1:0] MARK_OPEN = 2'd1;
    localparam logic [MARK_W-1:0] MARK_PATH = 2'd2;
    localparam logic [MARK_W-1:0] MARK_DEAD = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd3;
    localparam logic [DIR_W-1:0] DIR_DONE  = 3'd4;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } stk_ctrl_t;

endpackage

>>> rtl/gmds_stack.sv
// ----------------------------------------------------------------------------
// Grid maze solver search stack
// Frame memory with a depth pointer; a pop returns the popped frame in the next cycle.
// ----------------------------------------------------------------------------
module gmds_stack #(
    parameter int FRAME_W = 15,
    parameter int ADDR_W  = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  gmds_pkg::stk_ctrl_t ctrl,
    input  logic [FRAME_W-1:0]  push_frame,
    output logic [FRAME_W-1:0]  top_frame,
    output logic                empty
);
    import gmds_pkg::*;

    logic [FRAME_W-1:0] frame_mem [2**ADDR_W];
    logic [ADDR_W:0]    sp_reg;
    logic [ADDR_W:0]    sp_next;
    logic [ADDR_W:0]    sp_dec;
    logic [FRAME_W-1:0] top_frame_reg;

    assign sp_dec    = sp_reg - (ADDR_W + 1)'(1);
    assign empty     = (sp_reg == '0);
    assign top_frame = top_frame_reg;

    always_comb
    begin
        sp_next = sp_reg;
        if (ctrl.clear)
        begin
            sp_next = '0;
        end
        else if (ctrl.push)
        begin
            sp_next = sp_reg + (ADDR_W + 1)'(1);
        end
        else if (ctrl.pop)
        begin
            sp_next = sp_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg <= '0;
        end
        else
        begin
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push && !ctrl.clear)
        begin
            frame_mem[sp_reg[ADDR_W-1:0]] <= push_frame;
        end
        if (ctrl.pop && !ctrl.clear)
        begin
            top_frame_reg <= frame_mem[sp_dec[ADDR_W-1:0]];
        end
    end

endmodule

>>> rtl/grid_maze_dfs_solver_unit.sv
// ----------------------------------------------------------------------------
// Grid maze depth-first solver
// Loads a wall/open grid, searches a path from top-left to bottom-right.
// ----------------------------------------------------------------------------
// Usage: the configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data)
// sets grid_width and grid_height; it is always ready. The user must write
// it only while the block is idle; the block itself does not enforce this.
// The input channel takes items with op, row, col and cell_open; the output
// channel returns path_found and cell_mark, one result item per input item.
// A load item writes its cell (if inside the grid) when it is taken; a read
// item reads the cell memory into a register and then returns the mark. A
// solve item first probes neighbors through the single cell memory read port
// (skipped directions read no cell; a backtrack reloads the popped frame),
// then sweeps width*height cells to turn dead ends back to open.
// The block takes the next item only when it is idle and its output register
// is free or being drained in the same cycle; a stalled receiver holds the
// result in that register and stops further input items.
// Reset clears the control state and sets both dimensions to 64; the cell
// store holds undefined marks until each cell is loaded.
// ----------------------------------------------------------------------------
module grid_maze_dfs_solver_unit #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gmds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gmds_pkg::DIM_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [gmds_pkg::OP_W-1:0]        op,
    input  logic [gmds_pkg::COORD_W-1:0]     row,
    input  logic [gmds_pkg::COORD_W-1:0]     col,
    input  logic                             cell_open,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             path_found,
    output logic [gmds_pkg::MARK_W-1:0]      cell_mark
);
    import gmds_pkg::*;

    localparam int XW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int AW      = XW + YW;
    localparam int WDW     = (XW + 1 > DIM_W) ? XW + 1 : DIM_W;
    localparam int HDW     = (YW + 1 > DIM_W) ? YW + 1 : DIM_W;
    localparam int FRAME_W = YW + XW + DIR_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDWAIT,
        S_STEP,
        S_CHECK,
        S_POP,
        S_SWEEP,
        S_SWLAST,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [DIM_W-1:0]  grid_width_reg, grid_width_next;
    logic [DIM_W-1:0]  grid_height_reg, grid_height_next;
    logic [XW-1:0]     cur_x_reg, cur_x_next;
    logic [YW-1:0]     cur_y_reg, cur_y_next;
    logic [DIR_W-1:0]  cur_dir_reg, cur_dir_next;
    logic [XW-1:0]     nb_x_reg, nb_x_next;
    logic [YW-1:0]     nb_y_reg, nb_y_next;
    logic [XW-1:0]     sw_x_reg, sw_x_next;
    logic [YW-1:0]     sw_y_reg, sw_y_next;
    logic [AW-1:0]     swa_reg, swa_next;
    logic              sw_valid_reg, sw_valid_next;
    logic              found_reg, found_next;
    logic              rd_inside_reg, rd_inside_next;
    logic              out_valid_reg, out_valid_next;
    logic              path_found_reg, path_found_next;
    logic [MARK_W-1:0] cell_mark_reg, cell_mark_next;

    logic [MARK_W-1:0] cell_mem [2**AW];
    logic [MARK_W-1:0] cm_rdata_reg;
    logic              cm_we;
    logic [AW-1:0]     cm_waddr;
    logic [MARK_W-1:0] cm_wdata;
    logic              cm_re;
    logic [AW-1:0]     cm_raddr;

    logic [WDW-1:0]    w_wide, w_eff;
    logic [HDW-1:0]    h_wide, h_eff;
    logic              in_grid;
    logic [AW-1:0]     in_addr;
    logic              out_free;
    logic              nb_ok;
    logic [XW-1:0]     nx;
    logic [YW-1:0]     ny;
    logic              nb_goal;
    logic              start_goal;
    logic              sw_x_last, sw_y_last;

    stk_ctrl_t          stk_ctrl;
    logic [FRAME_W-1:0] push_frame;
    logic [FRAME_W-1:0] top_frame;
    logic               stk_empty;

    gmds_stack #(
        .FRAME_W (FRAME_W),
        .ADDR_W  (AW)
    ) u_gmds_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (stk_ctrl),
        .push_frame (push_frame),
        .top_frame  (top_frame),
        .empty      (stk_empty)
    );

    assign w_wide = WDW'(grid_width_reg);
    assign h_wide = HDW'(grid_height_reg);
    assign w_eff  = (w_wide == '0) ? WDW'(1) :
                    (w_wide > WDW'(MAX_WIDTH)) ? WDW'(MAX_WIDTH) : w_wide;
    assign h_eff  = (h_wide == '0) ? HDW'(1) :
                    (h_wide > HDW'(MAX_HEIGHT)) ? HDW'(MAX_HEIGHT) : h_wide;

    assign in_grid    = (WDW'(col) < w_eff) && (HDW'(row) < h_eff);
    assign in_addr    = {YW'(row), XW'(col)};
    assign out_free   = !out_valid_reg || out_ready;
    assign start_goal = (w_eff == WDW'(1)) && (h_eff == HDW'(1));
    assign nb_goal    = (WDW'(nb_x_reg) == w_eff - WDW'(1)) &&
                        (HDW'(nb_y_reg) == h_eff - HDW'(1));
    assign sw_x_last  = (WDW'(sw_x_reg) == w_eff - WDW'(1));
    assign sw_y_last  = (HDW'(sw_y_reg) == h_eff - HDW'(1));
    assign push_frame = {cur_y_reg, cur_x_reg, cur_dir_reg};

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == S_IDLE) && out_free;
    assign out_valid  = out_valid_reg;
    assign path_found = path_found_reg;
    assign cell_mark  = cell_mark_reg;

    always_comb
    begin
        nb_ok = 1'b0;
        nx    = cur_x_reg;
        ny    = cur_y_reg;
        case (cur_dir_reg)
            DIR_RIGHT:
            begin
                nb_ok = (WDW'(cur_x_reg) + WDW'(1)) < w_eff;
                nx    = cur_x_reg + XW'(1);
            end
            DIR_DOWN:
            begin
                nb_ok = (HDW'(cur_y_reg) + HDW'(1)) < h_eff;
                ny    = cur_y_reg + YW'(1);
            end
            DIR_LEFT:
            begin
                nb_ok = (cur_x_reg != '0);
                nx    = cur_x_reg - XW'(1);
            end
            DIR_UP:
            begin
                nb_ok = (cur_y_reg != '0);
                ny    = cur_y_reg - YW'(1);
            end
            default:
            begin
                nb_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        cur_dir_next     = cur_dir_reg;
        nb_x_next        = nb_x_reg;
        nb_y_next        = nb_y_reg;
        sw_x_next        = sw_x_reg;
        sw_y_next        = sw_y_reg;
        swa_next         = swa_reg;
        sw_valid_next    = sw_valid_reg;
        found_next       = found_reg;
        rd_inside_next   = rd_inside_reg;
        out_valid_next   = out_valid_reg;
        path_found_next  = path_found_reg;
        cell_mark_next   = cell_mark_reg;
        cm_we            = 1'b0;
        cm_waddr         = '0;
        cm_wdata         = MARK_WALL;
        cm_re            = 1'b0;
        cm_raddr         = '0;
        stk_ctrl         = '0;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_next  = cfg_data;
                CFG_GRID_HEIGHT: grid_height_next = cfg_data;
                default:         grid_width_next  = grid_width_reg;
            endcase
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (op)
                        OP_LOAD:
                        begin
                            cm_we           = in_grid;
                            cm_waddr        = in_addr;
                            cm_wdata        = cell_open ? MARK_OPEN : MARK_WALL;
                            out_valid_next  = 1'b1;
                            path_found_next = 1'b0;
                            cell_mark_next  = MARK_WALL;
                        end
                        OP_SOLVE:
                        begin
                            cm_we          = 1'b1;
                            cm_waddr       = '0;
                            cm_wdata       = MARK_PATH;
                            stk_ctrl.clear = 1'b1;
                            cur_x_next     = '0;
                            cur_y_next     = '0;
                            cur_dir_next   = DIR_RIGHT;
                            sw_x_next      = '0;
                            sw_y_next      = '0;
                            sw_valid_next  = 1'b0;
                            found_next     = start_goal;
                            state_next     = start_goal ? S_SWEEP : S_STEP;
                        end
                        OP_READ:
                        begin
                            cm_re          = 1'b1;
                            cm_raddr       = in_addr;
                            rd_inside_next = in_grid;
                            state_next     = S_RDWAIT;
                        end
                        default:
                        begin
                            out_valid_next  = 1'b1;
                            path_found_next = 1'b0;
                            cell_mark_next  = MARK_WALL;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    path_found_next = 1'b0;
                    cell_mark_next  = rd_inside_reg ? cm_rdata_reg : MARK_WALL;
                    state_next      = S_IDLE;
                end
            end
            S_STEP:
            begin
                if (cur_dir_reg == DIR_DONE)
                begin
                    cm_we    = 1'b1;
                    cm_waddr = {cur_y_reg, cur_x_reg};
                    cm_wdata = MARK_DEAD;
                    if (stk_empty)
                    begin
                        found_next = 1'b0;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        stk_ctrl.pop = 1'b1;
                        state_next   = S_POP;
                    end
                end
                else
                begin
                    cur_dir_next = cur_dir_reg + DIR_W'(1);
                    if (nb_ok)
                    begin
                        cm_re      = 1'b1;
                        cm_raddr   = {ny, nx};
                        nb_x_next  = nx;
                        nb_y_next  = ny;
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                state_next = S_STEP;
                if (cm_rdata_reg == MARK_OPEN)
                begin
                    cm_we    = 1'b1;
                    cm_waddr = {nb_y_reg, nb_x_reg};
                    cm_wdata = MARK_PATH;
                    if (nb_goal)
                    begin
                        found_next = 1'b1;
                        state_next = S_SWEEP;
                    end
                    else
                    begin
                        stk_ctrl.push = 1'b1;
                        cur_x_next    = nb_x_reg;
                        cur_y_next    = nb_y_reg;
                        cur_dir_next  = DIR_RIGHT;
                    end
                end
            end
            S_POP:
            begin
                {cur_y_next, cur_x_next, cur_dir_next} = top_frame;
                state_next = S_STEP;
            end
            S_SWEEP:
            begin
                if (sw_valid_reg && (cm_rdata_reg == MARK_DEAD))
                begin
                    cm_we    = 1'b1;
                    cm_waddr = swa_reg;
                    cm_wdata = MARK_OPEN;
                end
                cm_re         = 1'b1;
                cm_raddr      = {sw_y_reg, sw_x_reg};
                swa_next      = {sw_y_reg, sw_x_reg};
                sw_valid_next = 1'b1;
                if (sw_x_last)
                begin
                    sw_x_next = '0;
                    if (sw_y_last)
                    begin
                        state_next = S_SWLAST;
                    end
                    else
                    begin
                        sw_y_next = sw_y_reg + YW'(1);
                    end
                end
                else
                begin
                    sw_x_next = sw_x_reg + XW'(1);
                end
            end
            S_SWLAST:
            begin
                if (sw_valid_reg && (cm_rdata_reg == MARK_DEAD))
                begin
                    cm_we    = 1'b1;
                    cm_waddr = swa_reg;
                    cm_wdata = MARK_OPEN;
                end
                sw_valid_next = 1'b0;
                state_next    = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    path_found_next = found_reg;
                    cell_mark_next  = MARK_WALL;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            grid_width_reg  <= DIM_RESET;
            grid_height_reg <= DIM_RESET;
            sw_valid_reg    <= 1'b0;
            found_reg       <= 1'b0;
            out_valid_reg   <= 1'b0;
            path_found_reg  <= 1'b0;
            cell_mark_reg   <= MARK_WALL;
        end
        else
        begin
            state_reg       <= state_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            sw_valid_reg    <= sw_valid_next;
            found_reg       <= found_next;
            out_valid_reg   <= out_valid_next;
            path_found_reg  <= path_found_next;
            cell_mark_reg   <= cell_mark_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        cur_dir_reg   <= cur_dir_next;
        nb_x_reg      <= nb_x_next;
        nb_y_reg      <= nb_y_next;
        sw_x_reg      <= sw_x_next;
        sw_y_reg      <= sw_y_next;
        swa_reg       <= swa_next;
        rd_inside_reg <= rd_inside_next;
    end

    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            cell_mem[cm_waddr] <= cm_wdata;
        end
        if (cm_re)
        begin
            cm_rdata_reg <= cell_mem[cm_raddr];
        end
    end

endmodule

>>> rtl/gmds_checker.sv
// ----------------------------------------------------------------------------
// Grid maze solver port checker
// Watches the item channels of the solver and tracks the operation in flight.
// ----------------------------------------------------------------------------
`include "grid_maze_dfs_solver_unit_macros.svh"

module gmds_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [gmds_pkg::OP_W-1:0]   op,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        path_found,
    input logic [gmds_pkg::MARK_W-1:0] cell_mark
);
    import gmds_pkg::*;

    logic [OP_W-1:0] last_op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_op_reg <= OP_LOAD;
        end
        else if (in_valid && in_ready)
        begin
            last_op_reg <= op;
        end
    end

    `GMDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(path_found) && $stable(cell_mark), "result item changed while stalled")
    `GMDS_ASSERT_NOW(a_in_gated, clk, rst_n, in_ready, !out_valid || out_ready, "input taken while output register is blocked")
    `GMDS_ASSERT_NOW(a_found_solve, clk, rst_n, out_valid && (last_op_reg != OP_SOLVE), !path_found, "path flag set outside a solve item")
    `GMDS_ASSERT_NOW(a_mark_read, clk, rst_n, out_valid && (last_op_reg != OP_READ), cell_mark == MARK_WALL, "cell mark set outside a read item")
    `GMDS_ASSERT_NEXT(a_load_one, clk, rst_n, in_valid && in_ready && (op == OP_LOAD), out_valid, "load item result not presented in the next cycle")

endmodule

bind grid_maze_dfs_solver_unit gmds_checker u_gmds_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .path_found (path_found),
    .cell_mark  (cell_mark)
);
